// File: rtl/glut_pkg.sv
// Package for the gamma table interpolator: sizes, request and command types.
// Used by the interfaces and every module under rtl; depends on nothing.
package glut_pkg;

  // Table and pixel geometry.
  localparam int TABLE_ENTRIES = 64;
  localparam int PIXEL_BITS    = 10;
  localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
  // Segment width in pixel codes; a power of two for the table sizes in use.
  localparam int STEP          = ((1 << PIXEL_BITS) / TABLE_ENTRIES == 0) ? 1 :
                                 (1 << PIXEL_BITS) / TABLE_ENTRIES;
  localparam int OFF_BITS      = (STEP > 1) ? $clog2(STEP) : 1;
  localparam int SEG_BITS      = PIXEL_BITS - $clog2(STEP);
  localparam int LAST_IDX      = TABLE_ENTRIES - 1;

  // Fixed field widths of the request and result.
  localparam int PIX_IN_BITS   = 10;
  localparam int TIDX_BITS     = 6;
  localparam int LUT_BITS      = 8;
  localparam int BYPASS_SHIFT  = 2;

  // Slope arithmetic: |L1-L0|*10 is at most 2550, and so is offset*slope.
  localparam int SLOPE_SCALE   = 10;
  localparam int MAG_BITS      = 12;
  // Division by ten as a multiply by 2^16/10 rounded up; exact below 16384.
  localparam int DIV10_MUL     = 6554;
  localparam int DIV10_SHIFT   = 16;
  localparam int DIV10_BITS    = MAG_BITS + DIV10_SHIFT;

  // Command queue between the front and the back.
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  // Request kinds.
  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_WRITE = 1'b1
  } kind_e;

  typedef struct packed {
    logic                   kind;
    logic [PIX_IN_BITS-1:0] pixel_in;
    logic [TIDX_BITS-1:0]   table_index;
    logic [LUT_BITS-1:0]    table_value;
    logic                   end_of_frame;
  } req_t;

  typedef struct packed {
    logic [LUT_BITS-1:0] pixel_out;
    logic                frame_last;
  } rsp_t;

  // Decoded command for the back end. For a write, addr_lo is the entry.
  typedef struct packed {
    kind_e               op;
    logic [IDX_BITS-1:0] addr_lo;
    logic [IDX_BITS-1:0] addr_hi;
    logic [OFF_BITS-1:0] offset;
    logic                bypass;
    logic [LUT_BITS-1:0] byp_value;
    logic [LUT_BITS-1:0] wr_value;
    logic                eof;
  } cmd_t;

  typedef struct packed {
    logic                     full;
    logic                     empty;
    logic [FIFO_CNT_BITS-1:0] count;
  } fifo_stat_t;

endpackage

// File: rtl/glut_in_if.sv
// Request channel of the gamma table interpolator: valid, ready and payload.
// Depends on glut_pkg for the request type.
interface glut_in_if;
  import glut_pkg::*;

  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/glut_out_if.sv
// Result channel of the gamma table interpolator: valid, ready and payload.
// Depends on glut_pkg for the result type.
interface glut_out_if;
  import glut_pkg::*;

  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/glut_front.sv
// Front end: accepts requests, decodes them into table commands and holds
// one command for the queue. Depends on glut_pkg and glut_in_if.
module glut_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                enable_i,
  glut_in_if.sink             req_i,
  input  glut_pkg::fifo_stat_t stat_i,
  output glut_pkg::cmd_t      cmd_o,
  output logic                push_o
);
  import glut_pkg::*;

  logic                valid_q, valid_d;
  cmd_t                cmd_q, cmd_d;
  logic                hold_free;
  logic                accept;
  logic                keep;
  logic [SEG_BITS-1:0] seg;
  logic [IDX_BITS-1:0] lo;
  logic [IDX_BITS-1:0] hi;

  // The holding register frees up whenever its command moves into the queue.
  assign hold_free = !valid_q || !stat_i.full;
  assign req_i.ready = hold_free;
  assign accept = req_i.valid && hold_free;
  assign push_o = valid_q && !stat_i.full;
  assign cmd_o = cmd_q;

  // Split the pixel into segment and offset, clamping both table indexes.
  assign seg = req_i.payload.pixel_in[PIXEL_BITS-1 -: SEG_BITS];
  always_comb begin
    if (int'(seg) > LAST_IDX) begin
      lo = IDX_BITS'(LAST_IDX);
    end else begin
      lo = IDX_BITS'(seg);
    end
    if (int'(lo) >= LAST_IDX) begin
      hi = IDX_BITS'(LAST_IDX);
    end else begin
      hi = lo + IDX_BITS'(1);
    end
  end

  // Build the command. Writes outside the table are accepted and dropped.
  always_comb begin
    cmd_d           = cmd_q;
    keep            = 1'b1;
    cmd_d.eof       = req_i.payload.end_of_frame;
    cmd_d.wr_value  = req_i.payload.table_value;
    cmd_d.bypass    = !enable_i;
    cmd_d.byp_value = LUT_BITS'(req_i.payload.pixel_in >> BYPASS_SHIFT);
    cmd_d.offset    = OFF_BITS'(req_i.payload.pixel_in & PIX_IN_BITS'(STEP - 1));
    if (req_i.payload.kind == KIND_WRITE) begin
      cmd_d.op      = KIND_WRITE;
      cmd_d.addr_lo = IDX_BITS'(req_i.payload.table_index);
      cmd_d.addr_hi = IDX_BITS'(req_i.payload.table_index);
      keep          = int'(req_i.payload.table_index) < TABLE_ENTRIES;
    end else begin
      cmd_d.op      = KIND_PIXEL;
      cmd_d.addr_lo = lo;
      cmd_d.addr_hi = hi;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (hold_free) begin
      valid_d = accept && keep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Command payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// File: rtl/glut_fifo.sv
// Short command queue between the front end and the back end.
// Depends on glut_pkg for the command and status types.
module glut_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  glut_pkg::cmd_t       cmd_i,
  input  logic                 pop_i,
  output glut_pkg::cmd_t       cmd_o,
  output glut_pkg::fifo_stat_t stat_o
);
  import glut_pkg::*;

  cmd_t                     slots_q [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wptr_q, wptr_d;
  logic [FIFO_PTR_BITS-1:0] rptr_q, rptr_d;
  logic [FIFO_CNT_BITS-1:0] count_q, count_d;

  assign stat_o.full  = (int'(count_q) == FIFO_DEPTH);
  assign stat_o.empty = (count_q == '0);
  assign stat_o.count = count_q;
  assign cmd_o        = slots_q[rptr_q];

  // Pointer and fill count update.
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (int'(wptr_q) == FIFO_DEPTH - 1) ? '0 : wptr_q + FIFO_PTR_BITS'(1);
    end
    if (pop_i) begin
      rptr_d = (int'(rptr_q) == FIFO_DEPTH - 1) ? '0 : rptr_q + FIFO_PTR_BITS'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + FIFO_CNT_BITS'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - FIFO_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wptr_q] <= cmd_i;
    end
  end

endmodule

// File: rtl/glut_back.sv
// Back end: gamma table memory and the four-stage interpolation pipeline.
// Depends on glut_pkg and glut_out_if.
module glut_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  glut_pkg::cmd_t       cmd_i,
  input  glut_pkg::fifo_stat_t stat_i,
  output logic                 pop_o,
  glut_out_if.source           rsp_o
);
  import glut_pkg::*;

  logic [LUT_BITS-1:0] table_q [TABLE_ENTRIES];

  logic                adv;
  logic                v1_q, v2_q, v3_q, v4_q;

  // Stage 1: table read.
  logic [LUT_BITS-1:0] l0_1_q, l1_1_q, byp_1_q;
  logic [OFF_BITS-1:0] off_1_q;
  logic                bypass_1_q, eof_1_q;

  // Stage 2: slope magnitude and sign.
  logic [LUT_BITS-1:0] mag_d;
  logic [MAG_BITS-1:0] mag10_d;
  logic [MAG_BITS-1:0] slope_2_q;
  logic [LUT_BITS-1:0] l0_2_q, byp_2_q;
  logic [OFF_BITS-1:0] off_2_q;
  logic                neg_2_q, bypass_2_q, eof_2_q;

  // Stage 3: offset times slope.
  logic [MAG_BITS-1:0] prod_3_q;
  logic [LUT_BITS-1:0] l0_3_q, byp_3_q;
  logic                neg_3_q, bypass_3_q, eof_3_q;

  // Stage 4: divide by ten, apply sign and add.
  logic [DIV10_BITS-1:0] recip_d;
  logic [LUT_BITS-1:0]   delta_d;
  rsp_t                  rsp_d, rsp_q;

  // The whole pipeline moves together whenever the result register can load.
  assign adv   = !v4_q || rsp_o.ready;
  assign pop_o = adv && !stat_i.empty;
  assign rsp_o.valid   = v4_q;
  assign rsp_o.payload = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= pop_o && (cmd_i.op == KIND_PIXEL);
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Table writes and the registered two-port read, in queue order.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      if (cmd_i.op == KIND_WRITE) begin
        table_q[cmd_i.addr_lo] <= cmd_i.wr_value;
      end else begin
        l0_1_q <= table_q[cmd_i.addr_lo];
        l1_1_q <= table_q[cmd_i.addr_hi];
      end
      off_1_q    <= cmd_i.offset;
      byp_1_q    <= cmd_i.byp_value;
      bypass_1_q <= cmd_i.bypass;
      eof_1_q    <= cmd_i.eof;
    end
  end

  // Slope magnitude: |L1 - L0| * 10 / STEP, truncated toward zero.
  assign mag_d   = (l1_1_q < l0_1_q) ? (l0_1_q - l1_1_q) : (l1_1_q - l0_1_q);
  assign mag10_d = MAG_BITS'(mag_d) * MAG_BITS'(SLOPE_SCALE);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      slope_2_q  <= mag10_d >> $clog2(STEP);
      neg_2_q    <= l1_1_q < l0_1_q;
      l0_2_q     <= l0_1_q;
      off_2_q    <= off_1_q;
      byp_2_q    <= byp_1_q;
      bypass_2_q <= bypass_1_q;
      eof_2_q    <= eof_1_q;
    end
  end

  // Product of offset and slope magnitude stays below 2551.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_3_q   <= MAG_BITS'(MAG_BITS'(off_2_q) * slope_2_q);
      neg_3_q    <= neg_2_q;
      l0_3_q     <= l0_2_q;
      byp_3_q    <= byp_2_q;
      bypass_3_q <= bypass_2_q;
      eof_3_q    <= eof_2_q;
    end
  end

  // Truncating division by ten on the magnitude, then signed add mod 256.
  assign recip_d = DIV10_BITS'(prod_3_q) * DIV10_BITS'(DIV10_MUL);
  assign delta_d = LUT_BITS'(recip_d >> DIV10_SHIFT);

  always_comb begin
    rsp_d.frame_last = eof_3_q;
    if (bypass_3_q) begin
      rsp_d.pixel_out = byp_3_q;
    end else if (neg_3_q) begin
      rsp_d.pixel_out = l0_3_q - delta_d;
    end else begin
      rsp_d.pixel_out = l0_3_q + delta_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rsp_q <= rsp_d;
    end
  end

endmodule

// File: rtl/gamma_lut_interpolator.sv
// Gamma table interpolator top level: one pixel per cycle sustained unless output stalls.
// Path: the front holding register, the command queue, then four back stages
// (table read, slope, product, divide and add) from request to result.
// Table writes take a slot in the same stream and produce no result.
// Reset clears all handshake state and sets enable to 1; table contents stay unset.
// Depends on glut_pkg, glut_in_if, glut_out_if, glut_front, glut_fifo, glut_back.
module gamma_lut_interpolator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  glut_in_if.sink    req_i,
  glut_out_if.source rsp_o
);
  import glut_pkg::*;

  logic       enable_q;
  cmd_t       front_cmd;
  cmd_t       head_cmd;
  logic       push;
  logic       pop;
  fifo_stat_t stat;

  // Enable register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      enable_q <= cfg_wdata_i;
    end
  end

  glut_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .enable_i (enable_q),
    .req_i    (req_i),
    .stat_i   (stat),
    .cmd_o    (front_cmd),
    .push_o   (push)
  );

  glut_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (stat)
  );

  glut_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (head_cmd),
    .stat_i (stat),
    .pop_o  (pop),
    .rsp_o  (rsp_o)
  );

  // The queue never overflows, never underflows and its count stays in range.
  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && stat.full && !pop))
    else $error("command pushed into a full queue");

  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && stat.empty))
    else $error("command popped from an empty queue");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(stat.count) <= FIFO_DEPTH)
    else $error("queue fill count out of range");

  // A full queue stalls the front end.
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.full && push) |-> 1'b0)
    else $error("front end pushed while the queue was full");

endmodule
